/* hdl/bts_pkg.sv */
// Package with token scanner types, codes and character class helpers.
package bts_pkg;

  typedef enum logic [1:0] {
    PH_IDLE    = 2'd0,
    PH_TOKEN   = 2'd1,
    PH_COMMENT = 2'd2,
    PH_DATA    = 2'd3
  } phase_t;

  localparam logic [2:0] K_EOF   = 3'd0;
  localparam logic [2:0] K_EOL   = 3'd1;
  localparam logic [2:0] K_CONST = 3'd2;
  localparam logic [2:0] K_TEXT  = 3'd3;
  localparam logic [2:0] K_SYM   = 3'd4;

  localparam logic [1:0] VK_INT  = 2'd0;
  localparam logic [1:0] VK_REAL = 2'd1;
  localparam logic [1:0] VK_STR  = 2'd2;

  localparam logic [1:0] ERR_NONE  = 2'd0;
  localparam logic [1:0] ERR_STR   = 2'd1;
  localparam logic [1:0] ERR_HEX   = 2'd2;

  localparam logic [7:0] CH_CR    = 8'd13;
  localparam logic [7:0] CH_LF    = 8'd10;
  localparam logic [7:0] CH_QUOTE = 8'h22;
  localparam logic [7:0] CH_APOS  = 8'h27;
  localparam logic [7:0] CH_SPACE = 8'h20;

  typedef struct packed {
    logic [2:0]  token_kind;
    logic [1:0]  value_kind;
    logic [7:0]  text_length;
    logic [15:0] start_line;
    logic [9:0]  start_col;
    logic        at_line_start;
    logic [1:0]  error_code;
  } tok_t;

  function automatic logic [7:0] lower_f(input logic [7:0] c);
    lower_f = (c >= "A" && c <= "Z") ? c + 8'd32 : c;
  endfunction

  function automatic logic is_digit_f(input logic [7:0] c);
    is_digit_f = (c >= "0" && c <= "9");
  endfunction

  function automatic logic is_alpha_f(input logic [7:0] c);
    is_alpha_f = (c >= "a" && c <= "z") || (c >= "A" && c <= "Z") || c == "_";
  endfunction

  function automatic logic is_cmp_f(input logic [7:0] c);
    is_cmp_f = (c == "<") || (c == "=") || (c == ">");
  endfunction

endpackage

/* hdl/bts_step.sv */
// Combinational scanner step: next state and up to two token descriptors.
module bts_step #(
  parameter int LEN_W  = 8,
  parameter int LINE_W = 16,
  parameter int COL_W  = 10,
  parameter int MAX_TOKEN_LEN = 255,
  parameter int MAX_LINE = 65535,
  parameter int MAX_COL = 1023
) (
  input  logic [7:0]        ch,
  input  logic              end_of_line,
  input  logic              end_of_file,
  input  logic              skip_eol,
  input  logic              data_mode,
  input  bts_pkg::phase_t   phase_i,
  input  logic [2:0]        kind_i,
  input  logic [1:0]        vk_i,
  input  logic              hex_i,
  input  logic              space_i,
  input  logic              zp_i,
  input  logic [7:0]        first_i,
  input  logic [7:0]        last_i,
  input  logic [LEN_W-1:0]  len_i,
  input  logic [LEN_W-1:0]  trail_i,
  input  logic [LINE_W-1:0] line_i,
  input  logic [COL_W-1:0]  col_i,
  input  logic [LINE_W-1:0] tline_i,
  input  logic [COL_W-1:0]  tcol_i,
  input  logic              lsf_i,
  output bts_pkg::phase_t   phase_o,
  output logic [2:0]        kind_o,
  output logic [1:0]        vk_o,
  output logic              hex_o,
  output logic              space_o,
  output logic              zp_o,
  output logic [7:0]        first_o,
  output logic [7:0]        last_o,
  output logic [LEN_W-1:0]  len_o,
  output logic [LEN_W-1:0]  trail_o,
  output logic [LINE_W-1:0] line_o,
  output logic [COL_W-1:0]  col_o,
  output logic [LINE_W-1:0] tline_o,
  output logic [COL_W-1:0]  tcol_o,
  output logic              lsf_o,
  output logic [1:0]        cnt_o,
  output bts_pkg::tok_t     tok0_o,
  output bts_pkg::tok_t     tok1_o
);
  import bts_pkg::*;

  localparam logic [LEN_W-1:0]  MAXL = LEN_W'(MAX_TOKEN_LEN);
  localparam logic [LINE_W-1:0] MAXN = LINE_W'(MAX_LINE);
  localparam logic [COL_W-1:0]  MAXC = COL_W'(MAX_COL);

  logic       eof, lend, pending, apos, cl_ok, dm_end;
  logic [7:0] cs, cn, lc;
  tok_t       t;

  function automatic logic [7:0] sat8(input logic [LEN_W-1:0] v);
    logic [31:0] w;
    w = 32'(v);
    sat8 = (w > 32'd255) ? 8'd255 : w[7:0];
  endfunction
  function automatic logic [15:0] sat16(input logic [LINE_W-1:0] v);
    logic [31:0] w;
    w = 32'(v);
    sat16 = (w > 32'd65535) ? 16'hffff : w[15:0];
  endfunction
  function automatic logic [9:0] sat10(input logic [COL_W-1:0] v);
    logic [31:0] w;
    w = 32'(v);
    sat10 = (w > 32'd1023) ? 10'd1023 : w[9:0];
  endfunction

  always_comb begin
    phase_o = phase_i; kind_o = kind_i; vk_o = vk_i; hex_o = hex_i;
    space_o = space_i; zp_o = zp_i; first_o = first_i; last_o = last_i;
    len_o = len_i; trail_o = trail_i; line_o = line_i; col_o = col_i;
    tline_o = tline_i; tcol_o = tcol_i; lsf_o = lsf_i;
    cnt_o = 2'd0; tok0_o = '0; tok1_o = '0; t = '0;
    cl_ok = 1'b0; dm_end = 1'b0; lc = '0;

    eof  = end_of_file;
    lend = !eof && (end_of_line || ch == CH_CR);
    cs   = eof ? 8'd0 : (lend ? CH_CR : ch);
    cn   = (cs == CH_APOS) ? CH_CR : cs;
    apos = !lend && ch == CH_APOS;
    pending = 1'b1;

    // Current token step; a terminator ends the token and falls through.
    if (phase_o == PH_DATA || phase_o == PH_TOKEN) begin
      t.token_kind = kind_o; t.value_kind = vk_o; t.text_length = sat8(len_o);
      t.start_line = sat16(tline_o); t.start_col = sat10(tcol_o);
      t.at_line_start = lsf_o; t.error_code = ERR_NONE;
      if (phase_o == PH_DATA) begin
        dm_end = cn == CH_CR || cn == CH_LF || cn == 8'd0 || cn == "," || cn == ":" ||
                 cn == CH_QUOTE;
        if (dm_end) begin
          if (vk_o == VK_INT && (last_o == "x" || last_o == "X")) t.error_code = ERR_HEX;
        end else begin
          pending = 1'b0;
        end
      end else if (kind_o == K_CONST && vk_o == VK_STR) begin
        if (cs == CH_QUOTE) begin
          pending = 1'b0;
          col_o = (col_o < MAXC) ? col_o + 1'b1 : MAXC;
        end else if (cs == 8'd0 || cs == CH_CR) begin
          t.error_code = ERR_STR;
        end else begin
          pending = 1'b0;
        end
      end else if (kind_o == K_CONST) begin
        lc = lower_f(cn);
        if (cn == "." && vk_o == VK_INT) vk_o = VK_REAL;
        if (lc == "x" && zp_o) hex_o = 1'b1;
        if (is_digit_f(cn) || (cn == "." && vk_i == VK_INT) || (lc == "x" && zp_i) ||
            (hex_o && lc >= "a" && lc <= "f")) begin
          pending = 1'b0;
        end else if (vk_o == VK_INT && (last_o == "x" || last_o == "X")) begin
          t.error_code = ERR_HEX;
        end
        t.value_kind = vk_o;
      end else if (kind_o == K_TEXT) begin
        if (is_alpha_f(cn) || is_digit_f(cn)) pending = 1'b0;
        else if (cn == "$" || cn == "%" || cn == "#" || cn == "!") begin
          pending = 1'b0;
          len_o = (len_o < MAXL) ? len_o + 1'b1 : MAXL;
          col_o = (col_o < MAXC) ? col_o + 1'b1 : MAXC;
          t.text_length = sat8(len_o);
        end
      end else begin
        if (is_cmp_f(first_o) && is_cmp_f(cn)) pending = 1'b0;
      end

      if (!pending && !(kind_o == K_TEXT && (cn == "$" || cn == "%" || cn == "#" ||
          cn == "!")) && !(phase_o == PH_TOKEN && kind_o == K_CONST && vk_i == VK_STR &&
          cs == CH_QUOTE)) begin
        // Absorb the byte into the token.
        if (phase_o == PH_DATA) begin
          if (vk_o != VK_STR) begin
            lc = lower_f(cn);
            if (cn == "." && vk_o == VK_INT) vk_o = VK_REAL;
            if (lc == "x" && zp_o) hex_o = 1'b1;
            cl_ok = is_digit_f(cn) || (cn == "." && vk_i == VK_INT) || (lc == "x" && zp_i) ||
                    (hex_o && lc >= "a" && lc <= "f") || cn <= CH_SPACE;
            if (!cl_ok || (cn > CH_SPACE && space_o)) vk_o = VK_STR;
          end
          if (cn <= CH_SPACE) space_o = 1'b1;
        end
        zp_o = (cs == "0" && ((len_o + trail_o) == '0 ||
               ((len_o + trail_o) == LEN_W'(1) && first_o == "-")));
        if ((len_o + trail_o) == '0) first_o = (phase_o == PH_DATA) ? cn : cs;
        last_o = (phase_o == PH_DATA) ? cn : cs;
        if (phase_o == PH_DATA && cn <= CH_SPACE) begin
          trail_o = (trail_o < MAXL) ? trail_o + 1'b1 : MAXL;
        end else begin
          len_o = ((LEN_W+1)'(len_o) + (LEN_W+1)'(trail_o) + 1'b1 >= (LEN_W+1)'(MAXL)) ?
                  MAXL : len_o + trail_o + 1'b1;
          trail_o = '0;
        end
        col_o = (col_o < MAXC) ? col_o + 1'b1 : MAXC;
      end
      if (pending || (!pending && kind_o == K_TEXT && (cn == "$" || cn == "%" ||
          cn == "#" || cn == "!")) || (!pending && phase_o == PH_TOKEN &&
          kind_o == K_CONST && vk_i == VK_STR && cs == CH_QUOTE)) begin
        tok0_o = t;
        cnt_o = 2'd1;
        phase_o = PH_IDLE;
        lsf_o = (col_o == '0);
      end
    end else if (phase_o == PH_COMMENT) begin
      if (eof) phase_o = PH_IDLE;
      else begin
        if (lend) phase_o = PH_IDLE;
        pending = 1'b0;
      end
    end

    // Scan a byte that no token took: end of file, end of line, blank or a new token.
    if (pending) begin
      t = '0;
      t.start_line = sat16(line_o); t.start_col = sat10(col_o); t.at_line_start = lsf_o;
      if (eof) begin
        t.token_kind = K_EOF;
        if (cnt_o == 2'd1) tok1_o = t; else tok0_o = t;
        cnt_o = cnt_o + 1'b1;
      end else if (lend || apos) begin
        if (!skip_eol) begin
          t.token_kind = K_EOL; t.at_line_start = 1'b1;
          if (cnt_o == 2'd1) tok1_o = t; else tok0_o = t;
          cnt_o = cnt_o + 1'b1;
        end
        line_o = (line_o < MAXN) ? line_o + 1'b1 : MAXN;
        col_o = '0;
        lsf_o = 1'b1;
        if (apos) phase_o = PH_COMMENT;
      end else if (ch <= CH_SPACE) begin
        col_o = (col_o < MAXC) ? col_o + 1'b1 : MAXC;
      end else begin
        tline_o = line_o; tcol_o = col_o;
        col_o = (col_o < MAXC) ? col_o + 1'b1 : MAXC;
        hex_o = 1'b0; space_o = 1'b0; zp_o = 1'b0; trail_o = '0;
        first_o = ch; last_o = ch;
        len_o = LEN_W'(1);
        phase_o = PH_TOKEN;
        vk_o = VK_INT;
        if (ch == CH_QUOTE) begin
          kind_o = K_CONST; vk_o = VK_STR; len_o = '0; first_o = '0; last_o = '0;
        end else if (!data_mode) begin
          zp_o = (ch == "0");
          if (is_digit_f(ch) || ch == ".") begin
            kind_o = K_CONST;
            if (ch == ".") vk_o = VK_REAL;
          end else if (is_alpha_f(ch)) kind_o = K_TEXT;
          else kind_o = K_SYM;
        end else if (ch == "," || ch == ":") begin
          kind_o = K_SYM;
        end else begin
          kind_o = K_CONST;
          phase_o = PH_DATA;
          zp_o = (ch == "0");
          lc = lower_f(ch);
          cl_ok = is_digit_f(ch) || ch == "." || ch == "-";
          if (ch == ".") vk_o = VK_REAL;
          if (!cl_ok) vk_o = VK_STR;
        end
      end
    end
  end
endmodule

/* hdl/basic_token_scanner_core.sv */
// A token is shown in the cycle after the byte that ends it is accepted.
// Input: one request per cycle while the output is taken; a request causing two
// tokens holds the input while the second token waits behind the first.
// Reset: synchronous active-low rst_n returns the scanner to idle at line 0,
// column 0, with the output register empty.
// Top level of the BASIC token scanner.
module basic_token_scanner_core #(
  parameter int MAX_TOKEN_LEN = 255,
  parameter int MAX_LINE = 65535,
  parameter int MAX_COL = 1023
) (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       in_valid,
  output logic       in_ready,
  input  logic [7:0] in_ch,
  input  logic       in_end_of_line,
  input  logic       in_end_of_file,
  input  logic       in_skip_eol,
  input  logic       in_data_mode,
  output logic       out_valid,
  input  logic       out_ready,
  output logic [2:0] out_token_kind,
  output logic [1:0] out_value_kind,
  output logic [7:0] out_text_length,
  output logic [15:0] out_start_line,
  output logic [9:0] out_start_col,
  output logic       out_at_line_start,
  output logic [1:0] out_error_code,
  output logic       out_is_last
);
  import bts_pkg::*;

  localparam int LEN_W  = $clog2(MAX_TOKEN_LEN + 1);
  localparam int LINE_W = $clog2(MAX_LINE + 1);
  localparam int COL_W  = $clog2(MAX_COL + 1);

  phase_t phase_r, phase_nxt;
  logic [2:0] kind_r, kind_nxt;
  logic [1:0] vk_r, vk_nxt;
  logic hex_r, hex_nxt, space_r, space_nxt, zp_r, zp_nxt, lsf_r, lsf_nxt;
  logic [7:0] first_r, first_nxt, last_r, last_nxt;
  logic [LEN_W-1:0] len_r, len_nxt, trail_r, trail_nxt;
  logic [LINE_W-1:0] line_r, line_nxt, tline_r, tline_nxt;
  logic [COL_W-1:0] col_r, col_nxt, tcol_r, tcol_nxt;
  logic [1:0] cnt;
  tok_t tok0, tok1;

  // Two-entry result buffer: slot 0 is shown, slot 1 waits behind it.
  tok_t q0_r, q1_r;
  logic q0v_r, q1v_r, q0l_r, q1l_r;
  logic in_acc, out_acc;

  assign in_ready = !q1v_r && (!q0v_r || out_ready);
  assign in_acc = in_valid && in_ready;
  assign out_acc = out_valid && out_ready;

  bts_step #(.LEN_W(LEN_W), .LINE_W(LINE_W), .COL_W(COL_W),
    .MAX_TOKEN_LEN(MAX_TOKEN_LEN), .MAX_LINE(MAX_LINE), .MAX_COL(MAX_COL)) u_step (
    .ch(in_ch), .end_of_line(in_end_of_line), .end_of_file(in_end_of_file),
    .skip_eol(in_skip_eol), .data_mode(in_data_mode),
    .phase_i(phase_r), .kind_i(kind_r), .vk_i(vk_r), .hex_i(hex_r), .space_i(space_r),
    .zp_i(zp_r), .first_i(first_r), .last_i(last_r), .len_i(len_r), .trail_i(trail_r),
    .line_i(line_r), .col_i(col_r), .tline_i(tline_r), .tcol_i(tcol_r), .lsf_i(lsf_r),
    .phase_o(phase_nxt), .kind_o(kind_nxt), .vk_o(vk_nxt), .hex_o(hex_nxt),
    .space_o(space_nxt), .zp_o(zp_nxt), .first_o(first_nxt), .last_o(last_nxt),
    .len_o(len_nxt), .trail_o(trail_nxt), .line_o(line_nxt), .col_o(col_nxt),
    .tline_o(tline_nxt), .tcol_o(tcol_nxt), .lsf_o(lsf_nxt),
    .cnt_o(cnt), .tok0_o(tok0), .tok1_o(tok1)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r <= PH_IDLE; kind_r <= '0; vk_r <= '0; hex_r <= 1'b0; space_r <= 1'b0;
      zp_r <= 1'b0; first_r <= '0; last_r <= '0; len_r <= '0; trail_r <= '0;
      line_r <= '0; col_r <= '0; tline_r <= '0; tcol_r <= '0; lsf_r <= 1'b1;
      q0v_r <= 1'b0; q1v_r <= 1'b0;
    end else begin
      if (in_acc) begin
        phase_r <= phase_nxt; kind_r <= kind_nxt; vk_r <= vk_nxt; hex_r <= hex_nxt;
        space_r <= space_nxt; zp_r <= zp_nxt; first_r <= first_nxt; last_r <= last_nxt;
        len_r <= len_nxt; trail_r <= trail_nxt; line_r <= line_nxt; col_r <= col_nxt;
        tline_r <= tline_nxt; tcol_r <= tcol_nxt; lsf_r <= lsf_nxt;
      end
      if (in_acc) begin
        // in_acc implies slot 1 empty and slot 0 empty or leaving.
        q0v_r <= (cnt != 2'd0);
        q1v_r <= (cnt == 2'd2);
      end else if (out_acc) begin
        q0v_r <= q1v_r;
        q1v_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_acc) begin
      q0_r <= tok0; q0l_r <= (cnt == 2'd1);
      q1_r <= tok1; q1l_r <= 1'b1;
    end else if (out_acc) begin
      q0_r <= q1_r; q0l_r <= q1l_r;
    end
  end

  assign out_valid = q0v_r;
  assign out_token_kind = q0_r.token_kind;
  assign out_value_kind = q0_r.value_kind;
  assign out_text_length = q0_r.text_length;
  assign out_start_line = q0_r.start_line;
  assign out_start_col = q0_r.start_col;
  assign out_at_line_start = q0_r.at_line_start;
  assign out_error_code = q0_r.error_code;
  assign out_is_last = q0l_r;
endmodule

/* hdl/bts_checker.sv */
// Port-level checker for the token scanner, bound to the top level.
module bts_checker (
  input logic       clk,
  input logic       rst_n,
  input logic       in_valid,
  input logic       in_ready,
  input logic       out_valid,
  input logic       out_ready,
  input logic [2:0] out_token_kind,
  input logic [1:0] out_error_code,
  input logic [7:0] out_text_length,
  input logic       out_is_last
);
  import bts_pkg::*;

  a_kind: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> out_token_kind <= K_SYM) else $error("bad token kind");
  a_marker: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && (out_token_kind == K_EOF || out_token_kind == K_EOL) |->
    out_error_code == ERR_NONE && out_text_length == 8'd0) else $error("marker fields");
  a_pair: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_is_last |-> !in_ready) else $error("request taken mid pair");
  a_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid) else $error("result dropped");
endmodule

bind basic_token_scanner_core bts_checker u_bts_checker (
  .clk(clk), .rst_n(rst_n), .in_valid(in_valid), .in_ready(in_ready),
  .out_valid(out_valid), .out_ready(out_ready), .out_token_kind(out_token_kind),
  .out_error_code(out_error_code), .out_text_length(out_text_length),
  .out_is_last(out_is_last)
);
